FILE: design/mes_pkg.sv
// shared types and constants for the mandelbrot escape shader
package mes_pkg;

    localparam int PIX_W   = 9;
    localparam int COORD_W = 32;
    localparam int STEP_W  = 31;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_MAX_W = 10;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IMAG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP = 2'd3;

    localparam logic signed [COORD_W-1:0] RST_MIN_REAL  = -32'sd483183821;
    localparam logic signed [COORD_W-1:0] RST_MAX_IMAG  = 32'sd322122547;
    localparam logic        [STEP_W-1:0]  RST_REAL_STEP = 31'd1237278;
    localparam logic        [STEP_W-1:0]  RST_IMAG_STEP = 31'd1237278;

    // word passed from cell to cell along the coordinate chain
    typedef struct packed {
        logic                      valid;
        logic [PIX_W-1:0]          px;
        logic [PIX_W-1:0]          py;
        logic signed [COORD_W-1:0] c_re;
        logic signed [COORD_W-1:0] c_im;
    } t_coord_word;

endpackage

FILE: design/mandelbrot_escape_shader.sv
// mandelbrot escape shader top: config registers, coordinate chain, iteration unit
// a pixel passes the coordinate chain, then a square and an update state per magnitude
// test (e+1 tests on escape at e, ITERATION_CAP otherwise), then the output register
// one pixel in flight; the next pixel is taken the cycle after its result is registered,
// so a new pixel waits for the last result, which a stalled output can hold back
// reset (i_rst_n low, synchronous) empties the block and reloads the default view
module mandelbrot_escape_shader #(
    parameter int FRACTION_BITS = 28,
    parameter int ITERATION_CAP = 255
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,   // pixel_x, pixel_y, zero pad
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [15:0]                     o_m_axis_tdata,   // gray_level, escape_count
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mes_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mes_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int CNT_W = $clog2(ITERATION_CAP + 1);
    localparam int PIX_W = mes_pkg::PIX_W;
    localparam logic [7:0] GRAY_LIMITS [16] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
        8'd8, 8'd9, 8'd10, 8'd20, 8'd30, 8'd50, 8'd100, 8'd255
    };

    function automatic logic [7:0] gray_of(input logic [mes_pkg::CNT_MAX_W-1:0] e);
        logic [7:0] level;
        level = '0;
        for (int k = 0; k < 16; k++) begin
            if (mes_pkg::CNT_MAX_W'(GRAY_LIMITS[k]) <= e) begin
                level = GRAY_LIMITS[k];
            end
        end
        return 8'd255 - level;
    endfunction

    logic signed [mes_pkg::COORD_W-1:0] r_min_real;
    logic signed [mes_pkg::COORD_W-1:0] r_max_imag;
    logic        [mes_pkg::STEP_W-1:0]  r_real_step;
    logic        [mes_pkg::STEP_W-1:0]  r_imag_step;
    logic                               r_busy;
    logic                               r_out_valid;
    logic [7:0]                         r_gray;
    logic [7:0]                         r_escape;

    logic                               w_s_acc;
    logic                               w_done;
    logic                               w_take;
    logic [CNT_W-1:0]                   w_count;
    mes_pkg::t_coord_word               w_chain [PIX_W+1];

    assign o_s_axis_tready = !r_busy;
    assign o_cfg_ready     = 1'b1;
    assign w_s_acc         = i_s_axis_tvalid && !r_busy;
    assign w_take          = w_done && (!r_out_valid || i_m_axis_tready);

    assign w_chain[0].valid = w_s_acc;
    assign w_chain[0].px    = i_s_axis_tdata[PIX_W-1:0];
    assign w_chain[0].py    = i_s_axis_tdata[2*PIX_W-1:PIX_W];
    assign w_chain[0].c_re  = r_min_real;
    assign w_chain[0].c_im  = r_max_imag;

    // one cell per pixel index bit, the partial point moves one cell a cycle
    for (genvar g = 0; g < PIX_W; g++) begin : g_cell
        mes_coord_cell #(
            .BIT (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_real_step (r_real_step),
            .i_imag_step (r_imag_step),
            .i_word      (w_chain[g]),
            .o_word      (w_chain[g+1])
        );
    end

    mes_iter_unit #(
        .FRACTION_BITS (FRACTION_BITS),
        .ITERATION_CAP (ITERATION_CAP),
        .CNT_W         (CNT_W)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_chain[PIX_W].valid),
        .i_c_re  (w_chain[PIX_W].c_re),
        .i_c_im  (w_chain[PIX_W].c_im),
        .i_take  (w_take),
        .o_done  (w_done),
        .o_count (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_min_real  <= mes_pkg::RST_MIN_REAL;
            r_max_imag  <= mes_pkg::RST_MAX_IMAG;
            r_real_step <= mes_pkg::RST_REAL_STEP;
            r_imag_step <= mes_pkg::RST_IMAG_STEP;
        end else begin
            if (w_s_acc) begin
                r_busy <= 1'b1;
            end else if (w_take) begin
                r_busy <= 1'b0;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mes_pkg::CFG_MIN_REAL:  r_min_real  <= $signed(i_cfg_data);
                    mes_pkg::CFG_MAX_IMAG:  r_max_imag  <= $signed(i_cfg_data);
                    mes_pkg::CFG_REAL_STEP: r_real_step <= i_cfg_data[mes_pkg::STEP_W-1:0];
                    mes_pkg::CFG_IMAG_STEP: r_imag_step <= i_cfg_data[mes_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_gray   <= gray_of(mes_pkg::CNT_MAX_W'(w_count));
            r_escape <= 8'(w_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_escape, r_gray};

endmodule

FILE: design/mes_coord_cell.sv
// one cell of the coordinate chain: adds the shifted steps for one pixel index bit
module mes_coord_cell #(
    parameter int BIT = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic        [mes_pkg::STEP_W-1:0]  i_real_step,
    input  logic        [mes_pkg::STEP_W-1:0]  i_imag_step,
    input  mes_pkg::t_coord_word               i_word,
    output mes_pkg::t_coord_word               o_word
);

    mes_pkg::t_coord_word r_word;
    logic [mes_pkg::COORD_W-1:0] w_add_re;
    logic [mes_pkg::COORD_W-1:0] w_sub_im;

    // sums wrap mod 2^32, matching the final 32-bit wrap of the exact value
    assign w_add_re = ({1'b0, i_real_step} << BIT);
    assign w_sub_im = ({1'b0, i_imag_step} << BIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= i_word.valid;
        end
        r_word.px   <= i_word.px;
        r_word.py   <= i_word.py;
        r_word.c_re <= i_word.px[BIT] ? i_word.c_re + $signed(w_add_re) : i_word.c_re;
        r_word.c_im <= i_word.py[BIT] ? i_word.c_im - $signed(w_sub_im) : i_word.c_im;
    end

    assign o_word = r_word;

endmodule

FILE: design/mes_iter_unit.sv
// shared escape iteration unit: square stage then update and magnitude test
module mes_iter_unit #(
    parameter int FRACTION_BITS = 28,
    parameter int ITERATION_CAP = 255,
    parameter int CNT_W         = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mes_pkg::COORD_W-1:0]  i_c_re,
    input  logic signed [mes_pkg::COORD_W-1:0]  i_c_im,
    input  logic                                i_take,
    output logic                                o_done,
    output logic        [CNT_W-1:0]             o_count
);

    localparam int PROD_W = 2 * mes_pkg::COORD_W;
    localparam int MAG_W  = ((PROD_W + 1 - FRACTION_BITS) > (FRACTION_BITS + 3)) ?
                            (PROD_W + 1 - FRACTION_BITS) : (FRACTION_BITS + 3);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_DONE
    } t_state;

    t_state r_state;
    logic signed [mes_pkg::COORD_W-1:0] r_re;
    logic signed [mes_pkg::COORD_W-1:0] r_im;
    logic signed [mes_pkg::COORD_W-1:0] r_c_re;
    logic signed [mes_pkg::COORD_W-1:0] r_c_im;
    logic        [PROD_W-1:0]           r_rr;
    logic        [PROD_W-1:0]           r_ii;
    logic signed [PROD_W-1:0]           r_ri;
    logic        [CNT_W-1:0]            r_n;
    logic        [CNT_W-1:0]            r_count;

    logic        [MAG_W-1:0]            w_mag;
    logic        [MAG_W-1:0]            w_four;
    logic                               w_escape;
    logic signed [PROD_W-1:0]           w_diff;
    logic signed [mes_pkg::COORD_W-1:0] w_new_re;
    logic signed [mes_pkg::COORD_W-1:0] w_new_im;

    // squares are never negative, so a logical shift is the floor
    assign w_mag    = MAG_W'(r_rr >> FRACTION_BITS) + MAG_W'(r_ii >> FRACTION_BITS);
    assign w_four   = MAG_W'(4) << FRACTION_BITS;
    assign w_escape = w_mag > w_four;
    assign w_diff   = $signed(r_rr) - $signed(r_ii);
    assign w_new_re = mes_pkg::COORD_W'(w_diff >>> FRACTION_BITS) + r_c_re;
    // 2*re*im scaled: shift one place less
    assign w_new_im = mes_pkg::COORD_W'(r_ri >>> (FRACTION_BITS - 1)) + r_c_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_re    <= i_c_re;
                        r_im    <= i_c_im;
                        r_c_re  <= i_c_re;
                        r_c_im  <= i_c_im;
                        r_n     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rr    <= r_re * r_re;
                    r_ii    <= r_im * r_im;
                    r_ri    <= r_re * r_im;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_escape) begin
                        r_count <= r_n;
                        r_state <= S_DONE;
                    end else if (r_n == CNT_W'(ITERATION_CAP - 1)) begin
                        r_count <= CNT_W'(ITERATION_CAP);
                        r_state <= S_DONE;
                    end else begin
                        r_re    <= w_new_re;
                        r_im    <= w_new_im;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_count = r_count;

endmodule

FILE: design/mes_checker.sv
// port-level checks for the mandelbrot escape shader, bound to the top level
module mes_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [15:0]                     o_m_axis_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready
);

    logic w_s_acc;
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // one pixel in flight: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_axis_tready)
        else $error("second pixel taken while busy");

    // no result can appear the cycle after a pixel enters
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared too early");

    // a nonzero shade means the count stayed below the top limit
    a_gray_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[7:0] != 8'd0) |-> (o_m_axis_tdata[15:8] != 8'd255))
        else $error("gray shade does not match escape count");

    // config channel never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind mandelbrot_escape_shader mes_checker u_mes_checker (.*);

FILE: tb/sv/shade_checker.sv
// checker for the mandelbrot escape shader: predicts each pixel's shade and compares
module shade_checker #(
    parameter int FRACTION_BITS = 28,
    parameter int ITERATION_CAP = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pix_valid,
    input  logic                          i_pix_ready,
    input  logic [23:0]                   i_pix_data,     // pixel_x, pixel_y, zero pad
    input  logic                          i_shade_valid,
    input  logic                          i_shade_ready,
    input  logic [15:0]                   i_shade_data,   // gray_level, escape_count
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mes_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import mes_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [7:0]       escape_count;
        logic [7:0]       gray_level;
    } t_shade;

    logic signed [COORD_W-1:0] view_min_re;
    logic signed [COORD_W-1:0] view_max_im;
    logic        [STEP_W-1:0]  view_re_step;
    logic        [STEP_W-1:0]  view_im_step;

    t_shade shade_q[$];
    int     fails = 0;

    function automatic longint wrap32(input longint v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic t_shade predict_shade(input logic [PIX_W-1:0] px,
                                             input logic [PIX_W-1:0] py);
        longint c_re;
        longint c_im;
        longint re;
        longint im;
        longint rr;
        longint ii;
        longint ri;
        longint nre;
        int     esc;
        int     level;
        t_shade r;
        c_re = wrap32(longint'(view_min_re) + longint'(px) * longint'(view_re_step));
        c_im = wrap32(longint'(view_max_im) - longint'(py) * longint'(view_im_step));
        re   = c_re;
        im   = c_im;
        esc  = ITERATION_CAP;
        for (int n = 0; n < ITERATION_CAP; n++) begin
            rr = re * re;
            ii = im * im;
            ri = re * im;
            // squares are never negative, so the shifts floor
            if ((rr >>> FRACTION_BITS) + (ii >>> FRACTION_BITS) >
                (longint'(4) <<< FRACTION_BITS)) begin
                esc = n;
                break;
            end
            nre = wrap32(((rr - ii) >>> FRACTION_BITS) + c_re);
            im  = wrap32((ri >>> (FRACTION_BITS - 1)) + c_im);
            re  = nre;
        end
        // gray steps: one by one up to ten, then coarse bands
        if (esc >= 255)
            level = 255;
        else if (esc >= 100)
            level = 100;
        else if (esc >= 50)
            level = 50;
        else if (esc >= 30)
            level = 30;
        else if (esc >= 20)
            level = 20;
        else if (esc >= 10)
            level = 10;
        else
            level = esc;
        r.px           = px;
        r.py           = py;
        r.escape_count = esc[7:0];
        r.gray_level   = 8'(255 - level);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got, input t_shade pix);
        if (want !== got) begin
            $display("%0t: pixel (%0d,%0d) %s expected %0d actual %0d",
                     $time, pix.px, pix.py, field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_shade want;
        if (!i_rst_n) begin
            view_min_re  = RST_MIN_REAL;
            view_max_im  = RST_MAX_IMAG;
            view_re_step = RST_REAL_STEP;
            view_im_step = RST_IMAG_STEP;
            shade_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_REAL:  view_min_re  = i_cfg_data;
                    CFG_MAX_IMAG:  view_max_im  = i_cfg_data;
                    CFG_REAL_STEP: view_re_step = i_cfg_data[STEP_W-1:0];
                    CFG_IMAG_STEP: view_im_step = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready)
                shade_q.push_back(predict_shade(i_pix_data[PIX_W-1:0],
                                                i_pix_data[2*PIX_W-1:PIX_W]));
            if (i_shade_valid && i_shade_ready) begin
                if (shade_q.size() == 0) begin
                    $display({"%0t: result word with no pixel pending, expected none, ",
                              "actual gray %0d count %0d"},
                             $time, i_shade_data[7:0], i_shade_data[15:8]);
                    fails++;
                end else begin
                    want = shade_q.pop_front();
                    check_field("gray_level", want.gray_level, i_shade_data[7:0], want);
                    check_field("escape_count", want.escape_count, i_shade_data[15:8], want);
                end
            end
        end
        o_pending    <= shade_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/sv/testbench.sv
// testbench top for the mandelbrot escape shader: clock, reset, pixel and view stimulus
module testbench;
    import mes_pkg::*;

    localparam int     HALF_PERIOD    = 6;
    localparam int     RESET_CYCLES   = 5;
    localparam int     IDLE_PERCENT   = 34;
    localparam int     HOLD_AFTER     = 60;
    localparam int     HOLD_CYCLES    = 1500;
    localparam int     WATCHDOG_LIMIT = 12000;
    localparam int     DRAIN_CYCLES   = 600;
    localparam int     PHASES         = 10;
    localparam int     PHASE_PIXELS   = 153;
    localparam longint UNIT           = longint'(1) << 28;   // 1.0 in Q4.28

    typedef enum int {VIEW_PLAIN, VIEW_DEEP, VIEW_WILD} t_view_kind;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    mandelbrot_escape_shader u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    shade_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_pix_valid   (s_tvalid),
        .i_pix_ready   (s_tready),
        .i_pix_data    (s_tdata),
        .i_shade_valid (m_tvalid),
        .i_shade_ready (m_tready),
        .i_shade_data  (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // any accepted word on any channel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, and one long hold-off so the input backs up
    initial begin : receiver
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_view(input logic [31:0] min_re, input logic [31:0] max_im,
                            input logic [31:0] re_step, input logic [31:0] im_step);
        write_reg(CFG_MIN_REAL, min_re);
        write_reg(CFG_MAX_IMAG, max_im);
        write_reg(CFG_REAL_STEP, re_step);
        write_reg(CFG_IMAG_STEP, im_step);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait until every pixel word sent so far has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_view(input t_view_kind kind);
        logic [31:0] min_re;
        logic [31:0] max_im;
        logic [31:0] re_step;
        logic [31:0] im_step;
        case (kind)
            VIEW_WILD: begin
                min_re  = $urandom;
                max_im  = $urandom;
                re_step = $urandom;
                im_step = $urandom;
            end
            VIEW_DEEP: begin
                // tiny window near the set boundary, long escape counts
                min_re  = 32'(-(UNIT * 77) / 100 + longint'($urandom_range(0, 1 << 20)));
                max_im  = 32'((UNIT * 12) / 100 + longint'($urandom_range(0, 1 << 20)));
                re_step = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 512))};
                im_step = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 512))};
            end
            default: begin
                min_re  = 32'(-(UNIT * 5) / 2 +
                              longint'($urandom_range(0, 32'(2 * UNIT))));
                max_im  = 32'(UNIT / 5 +
                              longint'($urandom_range(0, 32'((UNIT * 3) / 2))));
                re_step = {1'($urandom_range(0, 1)), 31'($urandom_range(1 << 18, 1 << 21))};
                im_step = {1'($urandom_range(0, 1)), 31'($urandom_range(1 << 18, 1 << 21))};
            end
        endcase
        set_view(min_re, max_im, re_step, im_step);
    endtask

    initial begin : stimulus
        t_view_kind kind;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default view from reset: corners, and two points inside the set
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd0, 9'd511);
        send_pixel(9'd511, 9'd0);
        send_pixel(9'd390, 9'd260);
        send_pixel(9'd128, 9'd256);
        settle();

        // all registers zero: c is the origin everywhere, never escapes
        set_view(32'h0, 32'h0, 32'h0, 32'h0);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        settle();

        // register extremes, coordinates wrap around, step bit 31 set
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd511, 9'd511);
        send_pixel(9'd1, 9'd1);
        send_pixel(9'd511, 9'd0);
        settle();
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        send_pixel(9'd0, 9'd0);
        settle();

        // quarter-unit grid: c = -2 sits on the radius, 0.25 is the cusp,
        // -i is periodic, 2.0 escapes on the second magnitude test
        set_view(32'(-2 * UNIT), 32'h0, 32'(UNIT / 4), 32'(UNIT / 4));
        send_pixel(9'd0, 9'd0);
        send_pixel(9'd8, 9'd0);
        send_pixel(9'd9, 9'd0);
        send_pixel(9'd8, 9'd4);
        send_pixel(9'd16, 9'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase == 7)
                kind = VIEW_DEEP;
            else if (phase % 4 == 2)
                kind = VIEW_WILD;
            else
                kind = VIEW_PLAIN;
            random_view(kind);
            calm = (phase == 4);
            repeat (PHASE_PIXELS)
                send_pixel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
